>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the timer bank rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/ptb_pkg.sv
// ---------------------------------------------------------------------------
// ptb_pkg
// shared types and codes of the periodic timer bank
// ---------------------------------------------------------------------------
package ptb_pkg;

    localparam int OPCODE_W = 2;
    localparam int TIDX_W   = 4;   // timer_index and expired_index width
    localparam int CNT_W    = 32;  // counter and interval width
    localparam int TIU_W    = 5;   // timers_in_use width
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ARM    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DISARM = 2'd2;

    // word index of the timers_in_use register (paddr[2])
    localparam logic REG_TIMERS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic rem_we;
        logic rel_we;
    } mem_ctl_t;

endpackage

>>> design/ptb_timer_mem.sv
// ---------------------------------------------------------------------------
// ptb_timer_mem
// remaining-count and reload memories, one write and one registered read
// port each, with per-entry valid bits standing in for the reset clear
// ---------------------------------------------------------------------------
module ptb_timer_mem
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mem_ctl_t                                ctl,
    input  logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] wr_addr,
    input  logic [CNT_W-1:0]                        rem_wdata,
    input  logic [CNT_W-1:0]                        rel_wdata,
    input  logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr,
    output logic [CNT_W-1:0]                        rd_rem,
    output logic [CNT_W-1:0]                        rd_rel
);

    logic [CNT_W-1:0]      rem_mem [NUM_TIMERS];
    logic [CNT_W-1:0]      rel_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] valid_reg;
    logic [CNT_W-1:0]      rd_rem_reg;
    logic [CNT_W-1:0]      rd_rel_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rem_we)
        begin
            rem_mem[wr_addr] <= rem_wdata;
        end
        if (ctl.rel_we)
        begin
            rel_mem[wr_addr] <= rel_wdata;
        end
        rd_rem_reg <= rem_mem[rd_addr];
        rd_rel_reg <= rel_mem[rd_addr];
    end

    // an entry becomes valid once both words are written by an arm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.rel_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_rem = rd_vld_reg ? rd_rem_reg : '0;
    assign rd_rel = rd_vld_reg ? rd_rel_reg : '0;

endmodule

>>> design/ptb_engine.sv
// ---------------------------------------------------------------------------
// ptb_engine
// command decode, tick scan sequencer and expiry reporting
// ---------------------------------------------------------------------------
module ptb_engine
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [TIDX_W-1:0]      timer_index,
    input  logic [CNT_W-1:0]       timeout_ticks,
    input  logic [CNT_W-1:0]       reload_ticks,
    input  logic [(($clog2(NUM_TIMERS + 1) > TIU_W) ? $clog2(NUM_TIMERS + 1) : TIU_W)-1:0] limit,
    output logic                   busy,
    output logic                   result_valid,
    output logic [TIDX_W-1:0]      expired_index,
    output logic                   last_expiry,
    output mem_ctl_t               mem_ctl,
    output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] wr_addr,
    output logic [CNT_W-1:0]       rem_wdata,
    output logic [CNT_W-1:0]       rel_wdata,
    output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr,
    input  logic [CNT_W-1:0]       rd_rem,
    input  logic [CNT_W-1:0]       rd_rel
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LIM_W = $clog2(NUM_TIMERS + 1);
    localparam int CMP_W = (LIM_W > TIU_W) ? LIM_W : TIU_W;

    state_t           state_reg, state_next;
    logic [CMP_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             proc_vld_reg;
    logic [IDX_W-1:0] proc_idx_reg;
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic             accept;
    logic [CMP_W-1:0] idx_ext;
    logic             in_range;
    logic [CNT_W-1:0] rem_dec;
    logic             expire;
    logic [CMP_W-1:0] pend_ext;

    assign accept   = start && (state_reg == ST_IDLE);
    assign idx_ext  = CMP_W'(timer_index);
    assign in_range = idx_ext < limit;
    assign rem_dec  = rd_rem - CNT_W'(1);
    assign expire   = proc_vld_reg && (rd_rem == CNT_W'(1));
    assign rd_addr  = rd_cnt_reg[IDX_W-1:0];
    assign pend_ext = CMP_W'(pend_idx_reg);

    // next state
    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rd_cnt_next = '0;
                if (accept && (opcode == OP_TICK) && (limit != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_cnt_next = rd_cnt_reg + CMP_W'(1);
                if (rd_cnt_reg == (limit - CMP_W'(1)))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: memory writes and result strobe
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        mem_ctl       = '0;
        wr_addr       = idx_ext[IDX_W-1:0];
        rem_wdata     = timeout_ticks;
        rel_wdata     = reload_ticks;
        result_valid  = 1'b0;
        last_expiry   = 1'b0;
        expired_index = pend_ext[TIDX_W-1:0];
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;

        if (accept && in_range && (opcode == OP_ARM))
        begin
            mem_ctl.rem_we = 1'b1;
            mem_ctl.rel_we = 1'b1;
        end
        else if (accept && in_range && (opcode == OP_DISARM))
        begin
            mem_ctl.rem_we = 1'b1;
            rem_wdata      = '0;
        end
        else if (proc_vld_reg && (rd_rem != '0))
        begin
            mem_ctl.rem_we = 1'b1;
            wr_addr        = proc_idx_reg;
            rem_wdata      = expire ? rd_rel : rem_dec;
        end

        // an expiry is held until the next one or the scan end shows if it is the last
        if (expire)
        begin
            result_valid  = pend_vld_reg;
            pend_vld_next = 1'b1;
            pend_idx_next = proc_idx_reg;
        end
        else if (state_reg == ST_DONE)
        begin
            result_valid  = pend_vld_reg;
            last_expiry   = 1'b1;
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            proc_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            proc_vld_reg <= (state_reg == ST_SCAN);
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        pend_idx_reg <= pend_idx_next;
    end

endmodule

>>> design/periodic_timer_bank.sv
// ---------------------------------------------------------------------------
// periodic_timer_bank
// bank of one-shot and periodic countdown timers with expiry reporting
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Arm and disarm items
// report nothing and leave busy low, so the next item can be taken in the
// following cycle. A tick item runs from its accept through the scan, which
// reads one timer per cycle through the single read port of the count
// memory and covers timers_in_use timers (capped at NUM_TIMERS); ST_LAST
// then finishes the last read-modify-write and ST_DONE reports the final
// expiry. busy is high from the cycle after the accept until the tick ends.
// A tick with timers_in_use at zero leaves busy low. Expiries come out in
// index order, at most one per cycle, each on the result ports for exactly
// one cycle with result_valid high; the receiver cannot stall them, so it
// must take every strobe. last_expiry marks the final expiry of a tick, and
// a tick with no expiry gives no strobe at all. Stores come out of reset
// cleared at once through per-entry valid bits, so there is no clearing
// pass. timers_in_use is written over the apb port at byte address 0 and
// should only be changed while busy is low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_timer_bank
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [TIDX_W-1:0]   timer_index,
    input  logic [CNT_W-1:0]    timeout_ticks,
    input  logic [CNT_W-1:0]    reload_ticks,
    // result channel
    output logic                result_valid,
    output logic [TIDX_W-1:0]   expired_index,
    output logic                last_expiry,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LIM_W = $clog2(NUM_TIMERS + 1);
    localparam int CMP_W = (LIM_W > TIU_W) ? LIM_W : TIU_W;

    logic [TIU_W-1:0] tiu_reg;
    logic             cfg_wr;
    logic [CMP_W-1:0] tiu_ext;
    logic [CMP_W-1:0] num_ext;
    logic [CMP_W-1:0] limit;

    mem_ctl_t         mem_ctl;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] rem_wdata;
    logic [CNT_W-1:0] rel_wdata;
    logic [CNT_W-1:0] rd_rem;
    logic [CNT_W-1:0] rd_rel;

    // register access, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMERS_IN_USE);
    assign prdata = (paddr[2] == REG_TIMERS_IN_USE) ? APB_DW'(tiu_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiu_reg <= '0;
        end
        else if (cfg_wr)
        begin
            tiu_reg <= pwdata[TIU_W-1:0];
        end
    end

    // timers scanned per tick, clamped to the bank size
    assign tiu_ext = CMP_W'(tiu_reg);
    assign num_ext = CMP_W'(NUM_TIMERS);
    assign limit   = (tiu_ext > num_ext) ? num_ext : tiu_ext;

    ptb_engine #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .timer_index  (timer_index),
        .timeout_ticks(timeout_ticks),
        .reload_ticks (reload_ticks),
        .limit        (limit),
        .busy         (busy),
        .result_valid (result_valid),
        .expired_index(expired_index),
        .last_expiry  (last_expiry),
        .mem_ctl      (mem_ctl),
        .wr_addr      (wr_addr),
        .rem_wdata    (rem_wdata),
        .rel_wdata    (rel_wdata),
        .rd_addr      (rd_addr),
        .rd_rem       (rd_rem),
        .rd_rel       (rd_rel)
    );

    ptb_timer_mem #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .wr_addr  (wr_addr),
        .rem_wdata(rem_wdata),
        .rel_wdata(rel_wdata),
        .rd_addr  (rd_addr),
        .rd_rem   (rd_rem),
        .rd_rel   (rd_rel)
    );

    // results only come out of a running scan
    `ASSERT_SAME(a_result_in_scan, clk, rst_n, result_valid, busy)
    // arm, disarm and unknown codes finish in the accept cycle
    `ASSERT_NEXT(a_cmd_single, clk, rst_n, start && !busy && (opcode != OP_TICK), !busy)
    // an empty bank tick finishes at once
    `ASSERT_NEXT(a_empty_tick, clk, rst_n, start && !busy && (limit == '0), !busy)
    // the final expiry closes the tick
    `ASSERT_NEXT(a_last_ends, clk, rst_n, result_valid && last_expiry, !busy)

endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the periodic timer bank
// ---------------------------------------------------------------------------
// Arm, disarm and tick items go in through the start/busy command channel
// and the expiries coming out of the result strobe are checked in order
// against a shadow copy of the counter and interval stores. timers_in_use is
// written over the apb port between phases, once the bank has gone quiet.
// A short directed part covers the corner cases, then random phases with
// mostly short timeouts keep expiries flowing.
// ---------------------------------------------------------------------------
module testbench;
    import ptb_pkg::*;

    localparam int NUM_TIMERS    = 16;
    // longer than the longest tick, with some margin on top
    localparam int SETTLE_CYCLES = NUM_TIMERS + 8;
    // random items with an effect; the directed part adds some thirty more
    localparam int ITEMS_PER_RUN = 100;
    localparam int RANDOM_PHASES = 5;
    // the fourth opcode value has no meaning, the bank must ignore it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // one command for the bank
    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [TIDX_W-1:0]   timer_index;
        logic [CNT_W-1:0]    timeout_ticks;
        logic [CNT_W-1:0]    reload_ticks;
        bit                  hold;   // wait for all expiries before sending
    } timer_cmd_t;

    // one expiry report
    typedef struct {
        logic [TIDX_W-1:0] index;
        logic              last;
    } expiry_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [TIDX_W-1:0]   timer_index = '0;
    logic [CNT_W-1:0]    timeout_ticks = '0;
    logic [CNT_W-1:0]    reload_ticks = '0;
    logic                result_valid;
    logic [TIDX_W-1:0]   expired_index;
    logic                last_expiry;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // shadow of the bank
    logic [CNT_W-1:0] shadow_remaining [NUM_TIMERS];
    logic [CNT_W-1:0] shadow_reload [NUM_TIMERS];
    logic [TIU_W-1:0] shadow_in_use;

    timer_cmd_t  cmd_queue [$];          // commands not yet handed to the bank
    expiry_t     expected_expiries [$];  // expiries predicted, not yet seen
    timer_cmd_t  current_cmd;
    bit          cmd_loaded = 1'b0;      // a command sits on the ports
    int unsigned gap_pct = 32;
    int          error_count = 0;

    periodic_timer_bank #(
        .NUM_TIMERS(NUM_TIMERS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .timer_index   (timer_index),
        .timeout_ticks (timeout_ticks),
        .reload_ticks  (reload_ticks),
        .result_valid  (result_valid),
        .expired_index (expired_index),
        .last_expiry   (last_expiry),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // apply one accepted command to the shadow stores, queue its expiries
    function automatic void advance_bank(input timer_cmd_t cmd);
        int unsigned span;
        int          first_hit;
        expiry_t     hit;
        span = (shadow_in_use > NUM_TIMERS) ? NUM_TIMERS : shadow_in_use;
        first_hit = expected_expiries.size();
        case (cmd.opcode)
            OP_ARM:
            begin
                if (cmd.timer_index < span)
                begin
                    shadow_remaining[cmd.timer_index] = cmd.timeout_ticks;
                    shadow_reload[cmd.timer_index] = cmd.reload_ticks;
                end
            end
            OP_DISARM:
            begin
                if (cmd.timer_index < span)
                    shadow_remaining[cmd.timer_index] = '0;
            end
            OP_TICK:
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (shadow_remaining[i] != '0)
                    begin
                        shadow_remaining[i] = shadow_remaining[i] - 1'b1;
                        if (shadow_remaining[i] == '0)
                        begin
                            // expired: reload, a zero interval leaves it idle
                            shadow_remaining[i] = shadow_reload[i];
                            hit.index = TIDX_W'(i);
                            hit.last = 1'b0;
                            expected_expiries.push_back(hit);
                        end
                    end
                end
                // flag the final expiry of this tick, if there was any
                if (expected_expiries.size() > first_hit)
                    expected_expiries[expected_expiries.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // driver: hands queued commands to the bank, with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                advance_bank(current_cmd);
                cmd_loaded = 1'b0;
            end
            // ports are free unless a command still waits for busy to drop
            if (!start || !busy)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct
                    && !(cmd_queue[0].hold && expected_expiries.size() != 0))
                begin
                    current_cmd = cmd_queue.pop_front();
                    cmd_loaded = 1'b1;
                    start <= 1'b1;
                    opcode <= current_cmd.opcode;
                    timer_index <= current_cmd.timer_index;
                    timeout_ticks <= current_cmd.timeout_ticks;
                    reload_ticks <= current_cmd.reload_ticks;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest predicted expiry
    always @(posedge clk)
    begin
        expiry_t want;
        if (rst_n && result_valid)
        begin
            if (expected_expiries.size() == 0)
            begin
                $error("expired_index: expected no expiry, got %0d", expired_index);
                error_count++;
            end
            else
            begin
                want = expected_expiries.pop_front();
                if (expired_index !== want.index)
                begin
                    $error("expired_index: expected %0d, got %0d", want.index,
                           expired_index);
                    error_count++;
                end
                if (last_expiry !== want.last)
                begin
                    $error("last_expiry: expected %0d, got %0d", want.last,
                           last_expiry);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [TIDX_W-1:0] idx,
                             input logic [CNT_W-1:0] tmo, input logic [CNT_W-1:0] rel,
                             input bit hold = 1'b0);
        timer_cmd_t cmd;
        cmd.opcode = op;
        cmd.timer_index = idx;
        cmd.timeout_ticks = tmo;
        cmd.reload_ticks = rel;
        cmd.hold = hold;
        cmd_queue.push_back(cmd);
    endtask

    // wait until everything sent has been taken and reported, then let any
    // silent tick run out
    task automatic wait_for_idle();
        while (cmd_queue.size() != 0 || cmd_loaded || expected_expiries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of timers_in_use, junk in the unused upper bits
    task automatic write_timers_in_use(input logic [TIU_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = APB_DW'($urandom);
        word[TIU_W-1:0] = value;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TIMERS_IN_USE, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_in_use = value;
    endtask

    // short timeouts mostly, so that timers actually expire
    function automatic logic [CNT_W-1:0] pick_timeout();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        else if (roll < 16)
            return CNT_W'($urandom);
        else
            return CNT_W'($urandom_range(1, 6));
    endfunction

    function automatic logic [CNT_W-1:0] pick_reload();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return '0;
        else if (roll < 90)
            return CNT_W'($urandom_range(1, 8));
        else
            return CNT_W'($urandom);
    endfunction

    // fill the queue with random commands until enough have an effect
    task automatic queue_random_phase(input int useful_items);
        int unsigned span;
        int unsigned roll;
        int          useful;
        logic [OPCODE_W-1:0] op;
        logic [TIDX_W-1:0]   idx;
        span = (shadow_in_use > NUM_TIMERS) ? NUM_TIMERS : shadow_in_use;
        useful = 0;
        while (useful < useful_items)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                op = OP_TICK;
            else if (roll < 80)
                op = OP_ARM;
            else if (roll < 94)
                op = OP_DISARM;
            else
                op = OP_UNUSED;
            // mostly timers in the scanned range, some beyond it
            if (span != 0 && $urandom_range(99) < 85)
                idx = TIDX_W'($urandom_range(span - 1));
            else
                idx = TIDX_W'($urandom);
            queue_cmd(op, idx, pick_timeout(), pick_reload(), $urandom_range(99) < 4);
            if (op == OP_TICK || (op != OP_UNUSED && idx < span))
                useful++;
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int per_phase;
        foreach (shadow_remaining[i])
        begin
            shadow_remaining[i] = '0;
            shadow_reload[i] = '0;
        end
        shadow_in_use = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // nothing in use after reset: ticks are empty, arms are dropped
        queue_cmd(OP_TICK, 4'hF, '1, '1);
        queue_cmd(OP_ARM, 4'd0, 32'd1, 32'd0);
        wait_for_idle();

        // full bank: one-shot, periodic, zero timeout, widest values
        write_timers_in_use(TIU_W'(NUM_TIMERS));
        queue_cmd(OP_ARM, 4'd0, 32'd1, 32'd0);
        queue_cmd(OP_ARM, 4'd15, 32'd2, 32'd1);
        queue_cmd(OP_ARM, 4'd5, 32'd0, 32'd3);
        queue_cmd(OP_ARM, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(OP_ARM, 4'd3, 32'd1, 32'd2);
        queue_cmd(OP_TICK, 4'd0, '0, '0);
        queue_cmd(OP_TICK, 4'd9, '1, '0);
        queue_cmd(OP_TICK, 4'd6, '0, '1);
        queue_cmd(OP_DISARM, 4'd15, '0, '0);
        queue_cmd(OP_UNUSED, 4'd15, 32'h5555_AAAA, 32'hAAAA_5555);
        queue_cmd(OP_ARM, 4'd10, 32'd1, 32'd0);
        queue_cmd(OP_ARM, 4'd11, 32'd1, 32'd0);
        queue_cmd(OP_TICK, 4'd0, '0, '0);
        // sender holds back here until the last expiry is out
        queue_cmd(OP_DISARM, 4'd3, '0, '0, 1'b1);
        queue_cmd(OP_TICK, 4'd0, '0, '0);
        wait_for_idle();

        // register beyond the bank size scans the whole bank
        write_timers_in_use(5'd31);
        queue_cmd(OP_ARM, 4'd15, 32'd1, 32'd0);
        queue_cmd(OP_ARM, 4'd13, 32'd2, 32'd0);
        queue_cmd(OP_TICK, 4'd0, '0, '0);
        wait_for_idle();

        // shrink: upper timers keep their counts but sit out the scan
        write_timers_in_use(5'd4);
        queue_cmd(OP_ARM, 4'd2, 32'd3, 32'd0);
        queue_cmd(OP_ARM, 4'd12, 32'd1, 32'd0);
        queue_cmd(OP_TICK, 4'd0, '0, '0);
        wait_for_idle();

        // grow again: timer 13 picks up where it stopped
        write_timers_in_use(TIU_W'(NUM_TIMERS));
        queue_cmd(OP_TICK, 4'd0, '0, '0);
        wait_for_idle();

        // single timer in use
        write_timers_in_use(5'd1);
        queue_cmd(OP_ARM, 4'd1, 32'd1, 32'd0);
        queue_cmd(OP_ARM, 4'd0, 32'd1, 32'd1);
        queue_cmd(OP_TICK, 4'd0, '0, '0);
        wait_for_idle();

        // random phases over several bank sizes, one without gaps
        per_phase = ITEMS_PER_RUN / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: write_timers_in_use(TIU_W'(NUM_TIMERS));
                1: write_timers_in_use(TIU_W'($urandom_range(2, NUM_TIMERS - 1)));
                2: write_timers_in_use(TIU_W'($urandom_range(NUM_TIMERS + 1, 31)));
                3: write_timers_in_use(TIU_W'(NUM_TIMERS));
                default: write_timers_in_use(TIU_W'($urandom_range(1, NUM_TIMERS)));
            endcase
            gap_pct = (p == 3) ? 0 : 32;
            queue_random_phase(per_phase);
            wait_for_idle();
        end

        if (error_count == 0)
            $display("periodic_timer_bank test passed");
        else
            $display("periodic_timer_bank test failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("periodic_timer_bank test failed");
        $finish;
    end

endmodule

>>> periodic_timer_bank.f
+incdir+design
design/ptb_pkg.sv
design/ptb_timer_mem.sv
design/ptb_engine.sv
design/periodic_timer_bank.sv
bench/testbench.sv
